/* design/mst_pkg.sv */
// Shared types and codes for the second-resolution timer table.
package mst_pkg;

	localparam int SLOT_W    = 6;
	localparam int KIND_W    = 2;
	localparam int EXP_TAG_W = 32;

	localparam logic FUNC_REG  = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		KIND_REG  = 2'd0,
		KIND_EXP  = 2'd1,
		KIND_FULL = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_TICK
	} st_t;

endpackage

/* design/multi_slot_second_timer_table.sv */
// Timer table top level: slot allocation, tick walk over slot memories, result register.
//
//  channel | signals                                        | role
//  --------+------------------------------------------------+-----------------------------
//  in      | in_valid, in_ready, func, delay_seconds, tag    | register a timer or tick
//  out     | out_valid, out_ready, kind, slot, expired_tag,  | one or more results per item
//          | any_active, last                               |
//
// A register item scans the busy bits one slot a cycle, then waits for the result register.
// A tick walks the count and tag memories one slot a cycle through their single
// read port, holding while an expiry waits on out_ready.
// Reset clears busy bits and control at once; the memories are not cleared.
// An expiry that cannot be transferred holds the walk; the result register
// frees the input side while its last result waits.
module multi_slot_second_timer_table
	import mst_pkg::*;
#(
	parameter int SLOT_COUNT = 64,
	parameter int DELAY_BITS = 16,
	parameter int TAG_BITS   = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  func,
	input  logic [DELAY_BITS-1:0] delay_seconds,
	input  logic [TAG_BITS-1:0]   tag,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [KIND_W-1:0]     kind,
	output logic [SLOT_W-1:0]     slot,
	output logic [EXP_TAG_W-1:0]  expired_tag,
	output logic                  any_active,
	output logic                  last
);

	localparam int IW = $clog2(SLOT_COUNT);
	localparam int CW = $clog2(SLOT_COUNT + 1);

	st_t state_q, state_d;

	logic [DELAY_BITS-1:0] rem_mem [SLOT_COUNT];
	logic [TAG_BITS-1:0]   tag_mem [SLOT_COUNT];

	logic [SLOT_COUNT-1:0] busy_q, long_q, exp_q;
	logic [CW-1:0]         cnt_q;
	logic [DELAY_BITS-1:0] delay_q;
	logic [TAG_BITS-1:0]   tag_in_q;
	logic                  none_q, act_q;

	logic                  v_s1;
	logic [IW-1:0]         idx_s1;
	logic [DELAY_BITS-1:0] rem_rd_q;
	logic [TAG_BITS-1:0]   tag_rd_q;

	logic                  out_valid_q, any_active_q, last_q;
	logic [KIND_W-1:0]     kind_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [EXP_TAG_W-1:0]  exp_tag_q;

	logic                  in_acc, out_free;
	logic [IW-1:0]         cur_idx;
	logic                  cur_busy, scan_last, cnt_more;
	logic                  s1_busy, s1_exp, stall, walk_end;
	logic [SLOT_COUNT-1:0] s1_bit;
	logic [TAG_BITS+EXP_TAG_W-1:0] tag_wide;

	logic                  out_load, ld_act, ld_last;
	kind_t                 ld_kind;
	logic [IW-1:0]         ld_slot;
	logic [EXP_TAG_W-1:0]  ld_tag;
	logic                  reg_wr, dec_wr, exp_clr, issue, s1_go, cnt_inc;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	assign cur_idx   = cnt_q[IW-1:0];
	assign cur_busy  = busy_q[cur_idx];
	assign scan_last = (cur_idx == IW'(SLOT_COUNT - 1));
	assign cnt_more  = (cnt_q < CW'(SLOT_COUNT));

	assign s1_busy   = busy_q[idx_s1];
	assign s1_exp    = s1_busy && !long_q[idx_s1];
	assign s1_bit    = {{(SLOT_COUNT-1){1'b0}}, 1'b1} << idx_s1;
	assign stall     = v_s1 && s1_exp && !out_free;
	assign walk_end  = !cnt_more && !v_s1;
	assign tag_wide  = {{EXP_TAG_W{1'b0}}, tag_rd_q};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = (func == FUNC_TICK) ? ST_TICK : ST_SCAN;
			end
			ST_SCAN: begin
				if (out_free && (!cur_busy || scan_last)) state_d = ST_IDLE;
			end
			ST_TICK: begin
				if (walk_end && (!none_q || out_free)) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// per-state actions
	always_comb begin
		out_load = 1'b0;
		ld_kind  = KIND_NONE;
		ld_slot  = '0;
		ld_tag   = '0;
		ld_act   = 1'b1;
		ld_last  = 1'b1;
		reg_wr   = 1'b0;
		dec_wr   = 1'b0;
		exp_clr  = 1'b0;
		issue    = 1'b0;
		s1_go    = 1'b0;
		cnt_inc  = 1'b0;
		case (state_q)
			ST_SCAN: begin
				cnt_inc = cur_busy && !scan_last;
				if (out_free && !cur_busy) begin
					reg_wr   = 1'b1;
					out_load = 1'b1;
					ld_kind  = KIND_REG;
					ld_slot  = cur_idx;
				end else if (out_free && scan_last) begin
					out_load = 1'b1;
					ld_kind  = KIND_FULL;
				end
			end
			ST_TICK: begin
				issue   = cnt_more && !stall;
				cnt_inc = issue;
				s1_go   = v_s1 && !stall;
				ld_act  = act_q;
				if (s1_go && s1_exp) begin
					exp_clr  = 1'b1;
					out_load = 1'b1;
					ld_kind  = KIND_EXP;
					ld_slot  = idx_s1;
					ld_tag   = tag_wide[EXP_TAG_W-1:0];
					ld_last  = ~|(exp_q & ~s1_bit);
				end else if (s1_go && s1_busy) begin
					dec_wr = 1'b1;
				end else if (walk_end && none_q && out_free) begin
					out_load = 1'b1;
					ld_kind  = KIND_NONE;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			busy_q  <= '0;
			long_q  <= '0;
			exp_q   <= '0;
			none_q  <= 1'b0;
			act_q   <= 1'b0;
			v_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) cnt_q <= '0;
			else if (cnt_inc) cnt_q <= cnt_q + CW'(1);
			if (in_acc && func == FUNC_TICK) begin
				exp_q  <= busy_q & ~long_q;
				none_q <= ~|(busy_q & ~long_q);
				act_q  <= |(busy_q & long_q);
			end else if (exp_clr) begin
				exp_q <= exp_q & ~s1_bit;
			end
			if (reg_wr) begin
				busy_q[cur_idx] <= 1'b1;
				long_q[cur_idx] <= (delay_q > DELAY_BITS'(1));
			end
			if (exp_clr) busy_q[idx_s1] <= 1'b0;
			if (dec_wr) long_q[idx_s1] <= (rem_rd_q > DELAY_BITS'(2));
			if (issue) v_s1 <= 1'b1;
			else if (s1_go) v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			delay_q  <= delay_seconds;
			tag_in_q <= tag;
		end
		if (issue) idx_s1 <= cur_idx;
	end

	// slot memories: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (reg_wr) begin
			rem_mem[cur_idx] <= delay_q;
			tag_mem[cur_idx] <= tag_in_q;
		end else if (dec_wr) begin
			rem_mem[idx_s1] <= rem_rd_q - DELAY_BITS'(1);
		end
		if (issue) begin
			rem_rd_q <= rem_mem[cur_idx];
			tag_rd_q <= tag_mem[cur_idx];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			kind_q       <= ld_kind;
			slot_q       <= SLOT_W'(ld_slot);
			exp_tag_q    <= ld_tag;
			any_active_q <= ld_act;
			last_q       <= ld_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign slot        = slot_q;
	assign expired_tag = exp_tag_q;
	assign any_active  = any_active_q;
	assign last        = last_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !out_load)
		else $error("result register overwritten before transfer");

	a_walk_drained: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> !v_s1)
		else $error("item accepted while tick walk still in flight");

	a_exp_frees: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && ld_kind == KIND_EXP |=> !busy_q[$past(idx_s1)])
		else $error("expired slot still busy");

	a_reg_sets: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && ld_kind == KIND_REG |=> busy_q[$past(cur_idx)])
		else $error("registered slot not marked busy");

	a_exp_subset: assert property (@(posedge clk) disable iff (!arst_n)
		(exp_q & ~busy_q) == '0)
		else $error("pending expiry on a free slot");

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the second-resolution timer table.
module tb_top;
	import mst_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS         = 64;
	localparam int DBITS         = 16;
	localparam int TBITS         = 32;
	localparam int SETTLE_CYCLES = SLOTS + 16;

	typedef struct packed {
		kind_t                kind;
		logic [SLOT_W-1:0]    slot;
		logic [EXP_TAG_W-1:0] exp_tag;
		logic                 any_active;
		logic                 last;
	} timer_result_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 in_valid      = 1'b0;
	logic                 in_ready;
	logic                 func          = FUNC_REG;
	logic [DBITS-1:0]     delay_seconds = '0;
	logic [TBITS-1:0]     tag           = '0;
	logic                 out_valid;
	logic                 out_ready     = 1'b0;
	logic [KIND_W-1:0]    kind;
	logic [SLOT_W-1:0]    slot;
	logic [EXP_TAG_W-1:0] expired_tag;
	logic                 any_active;
	logic                 last;

	// shadow copy of the timer table
	logic             busy_shadow [SLOTS];
	logic [DBITS-1:0] secs_left   [SLOTS];
	logic [TBITS-1:0] tag_shadow  [SLOTS];

	timer_result_t    expected_results [$];

	int               send_idle_pct  = 0;
	int               recv_stall_pct = 0;
	int               hold_request   = 0;
	int               hold_left      = 0;
	int unsigned      items_sent     = 0;
	int unsigned      mismatches     = 0;

	multi_slot_second_timer_table #(
		.SLOT_COUNT(SLOTS),
		.DELAY_BITS(DBITS),
		.TAG_BITS  (TBITS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.delay_seconds(delay_seconds),
		.tag          (tag),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.slot         (slot),
		.expired_tag  (expired_tag),
		.any_active   (any_active),
		.last         (last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Updates the shadow table for one accepted item and queues its results.
	function automatic void predict_table_step(input logic f, input logic [DBITS-1:0] d,
			input logic [TBITS-1:0] t);
		timer_result_t res [$];
		timer_result_t r;
		int            free_idx;
		logic          active;
		free_idx = -1;
		r = '0;
		if (f == FUNC_REG) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (!busy_shadow[i] && free_idx < 0)
					free_idx = i;
			end
			if (free_idx < 0) begin
				r.kind = KIND_FULL;
			end else begin
				busy_shadow[free_idx] = 1'b1;
				secs_left[free_idx]   = d;
				tag_shadow[free_idx]  = t;
				r.kind = KIND_REG;
				r.slot = SLOT_W'(free_idx);
			end
			res.push_back(r);
		end else begin
			for (int i = 0; i < SLOTS; i++) begin
				if (busy_shadow[i]) begin
					if (secs_left[i] <= 1) begin
						secs_left[i]   = '0;
						busy_shadow[i] = 1'b0;
						r.kind    = KIND_EXP;
						r.slot    = SLOT_W'(i);
						r.exp_tag = EXP_TAG_W'(tag_shadow[i]);
						res.push_back(r);
					end else begin
						secs_left[i] = secs_left[i] - 1'b1;
					end
				end
			end
			if (res.size() == 0) begin
				r.kind = KIND_NONE;
				res.push_back(r);
			end
		end
		active = 1'b0;
		for (int i = 0; i < SLOTS; i++)
			active |= busy_shadow[i];
		foreach (res[i]) begin
			res[i].any_active = active;
			res[i].last       = (i == res.size() - 1);
			expected_results.push_back(res[i]);
		end
	endfunction

	function automatic int busy_count();
		int n;
		n = 0;
		for (int i = 0; i < SLOTS; i++)
			n += busy_shadow[i];
		return n;
	endfunction

	// Offers one item, optionally after random idle cycles; returns at the accepting edge.
	task automatic send_item(input logic f, input logic [DBITS-1:0] d,
			input logic [TBITS-1:0] t);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		func          <= f;
		delay_seconds <= d;
		tag           <= t;
		do @(posedge clk); while (!in_ready);
		predict_table_step(f, d, t);
		items_sent++;
	endtask

	task automatic wait_all_results();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin : check_results
		timer_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result kind=%0d slot=%0d tag=%h act=%b last=%b",
						$realtime, kind, slot, expired_tag, any_active, last);
			end else begin
				want = expected_results.pop_front();
				if (kind !== want.kind || slot !== want.slot || expired_tag !== want.exp_tag ||
						any_active !== want.any_active || last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: mismatch exp kind=%0d slot=%0d tag=%h act=%b last=%b",
							$realtime, want.kind, want.slot, want.exp_tag, want.any_active,
							want.last,
							" / got kind=%0d slot=%0d tag=%h act=%b last=%b",
							kind, slot, expired_tag, any_active, last);
				end
			end
		end
	end

	task automatic test_empty_tick();
		send_item(FUNC_TICK, '0, '0);
	endtask

	task automatic test_register_extremes();
		send_item(FUNC_REG, 16'd0, 32'h0000_0000);
		send_item(FUNC_REG, 16'd1, 32'hFFFF_FFFF);
		send_item(FUNC_REG, 16'hFFFF, 32'h5A5A_5A5A);
		send_item(FUNC_REG, 16'd2, 32'hA5A5_A5A5);
	endtask

	// zero and one second timers leave together, lowest slot first
	task automatic test_tick_expiry_order();
		send_item(FUNC_TICK, 16'hFFFF, 32'hFFFF_FFFF);
	endtask

	task automatic test_slot_reuse();
		send_item(FUNC_REG, 16'd3, 32'h1234_5678);
		repeat (3) send_item(FUNC_TICK, '0, '0);
	endtask

	// fill every slot, overflow twice, then one tick that frees nearly all of them, then one more register
	task automatic test_table_full();
		int n;
		n = SLOTS - busy_count();
		repeat (n) send_item(FUNC_REG, DBITS'($urandom_range(0, 1)), $urandom);
		repeat (2) send_item(FUNC_REG, DBITS'($urandom_range(0, 65535)), $urandom);
		send_item(FUNC_TICK, '0, '0);
		send_item(FUNC_REG, 16'd1, $urandom);
		wait_all_results();
	endtask

	task automatic test_input_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_request   = 400;
		repeat (12) begin
			send_item(FUNC_REG, DBITS'($urandom_range(0, 3)), $urandom);
			send_item(FUNC_TICK, DBITS'($urandom_range(0, 65535)), $urandom);
		end
		wait_all_results();
	endtask

	task automatic test_random_traffic();
		int          idle_set  [4] = '{0, 67, 0, 13};
		int          stall_set [4] = '{0, 0, 67, 13};
		int unsigned target;
		int          roll;
		int          burst;
		logic [DBITS-1:0] d;
		for (int p = 0; p < 4; p++) begin
			send_idle_pct  = idle_set[p];
			recv_stall_pct = stall_set[p];
			target = items_sent + 65;
			while (items_sent < target) begin
				roll = $urandom_range(99);
				if (roll < 10) begin
					send_item(1'($urandom_range(0, 1)), DBITS'($urandom_range(0, 65535)),
						$urandom);
				end else if (roll < 55) begin
					burst = $urandom_range(1, 8);
					repeat (burst) begin
						roll = $urandom_range(99);
						if (roll < 60)
							d = DBITS'($urandom_range(0, 3));
						else if (roll < 95)
							d = DBITS'($urandom_range(4, 20));
						else
							d = DBITS'($urandom_range(0, 65535));
						send_item(FUNC_REG, d, $urandom);
					end
				end else begin
					burst = $urandom_range(1, 4);
					repeat (burst) send_item(FUNC_TICK, DBITS'($urandom), $urandom);
				end
			end
			wait_all_results();
		end
	endtask

	initial begin : run_tests
		for (int i = 0; i < SLOTS; i++) begin
			busy_shadow[i] = 1'b0;
			secs_left[i]   = '0;
			tag_shadow[i]  = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_tick();
		test_register_extremes();
		test_tick_expiry_order();
		test_slot_reuse();
		wait_all_results();
		test_table_full();
		test_input_backpressure();
		test_random_traffic();
		wait_all_results();
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
